@@ sv/pixel_format_converter_defines.svh @@
// ----------------------------------------------------------------------------
// pixel_format_converter_defines.svh
// assertion macros used by the checker file pfc_chk
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERTER_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_DEFINES_SVH

// assertion that is switched off while reset is low
`define PFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// assertion that must also hold while reset is low
`define PFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/pfc_pkg.sv @@
// ----------------------------------------------------------------------------
// pfc_pkg
// types and constants of the pixel format converter
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  localparam int unsigned ChanW   = 32;
  localparam int unsigned FmtW    = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned Lanes   = 4;

  localparam logic [FmtW-1:0]  FmtCount  = 4'd12;
  localparam logic [FmtW-1:0]  FmtReset  = 4'd3;
  localparam logic [ChanW-1:0] BitsOne   = 32'h3F80_0000;
  localparam logic [30:0]      HalfMaxMag = 31'h477F_E000;

  typedef enum logic [1:0] {
    KindUnorm8 = 2'd0,
    KindHalf   = 2'd1,
    KindSingle = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcFmt = 1'b0,
    CfgTgtFmt = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
    logic [ChanW-1:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
  } pix_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [FmtW-1:0]    data;
  } cfg_wr_t;

endpackage

`default_nettype wire

@@ sv/pfc_if.sv @@
// ----------------------------------------------------------------------------
// pfc_if
// valid/ready channels of the pixel format converter
// ----------------------------------------------------------------------------
`default_nettype none

interface pfc_in_if;
  logic              valid;
  logic              ready;
  pfc_pkg::pix_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pfc_out_if;
  logic              valid;
  logic              ready;
  pfc_pkg::pix_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pfc_cfg_if;
  logic              valid;
  logic              ready;
  pfc_pkg::cfg_wr_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/pixel_format_converter.sv @@
// ----------------------------------------------------------------------------
// pixel_format_converter
// an accepted input word is registered in color_q, then in out_q, before it shows as output valid
// throughput: one pixel word per cycle while the output is not stalled, in a two-stage lane pipeline
// four lanes decode then encode one channel each; the output register merges
// reset: pipeline empty, source and target formats both RGBA unorm8
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_format_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  pfc_cfg_if.sink           cfg_i,
  pfc_in_if.sink            in_i,
  pfc_out_if.source         out_o
);

  localparam int unsigned L = pfc_pkg::Lanes;

  // configuration registers
  logic [pfc_pkg::FmtW-1:0] src_fmt_q;
  logic [pfc_pkg::FmtW-1:0] tgt_fmt_q;

  // format decode
  logic           src_ok;
  logic           tgt_ok;
  logic           pass;
  pfc_pkg::kind_e skind;
  pfc_pkg::kind_e tkind;

  // lane words
  logic [pfc_pkg::ChanW-1:0] raw      [L];
  logic [pfc_pkg::ChanW-1:0] dec      [L];
  logic [pfc_pkg::ChanW-1:0] color_d  [L];
  logic [pfc_pkg::ChanW-1:0] color_q  [L];
  logic [pfc_pkg::ChanW-1:0] enc      [L];
  logic [pfc_pkg::ChanW-1:0] res      [L];
  logic [pfc_pkg::ChanW-1:0] pass_mask;

  // pipeline control
  logic              s1_valid_q;
  logic              s2_valid_q;
  logic              s1_en;
  logic              s2_en;
  pfc_pkg::pix_out_t out_d;
  pfc_pkg::pix_out_t out_q;

  // config port never stalls
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= pfc_pkg::FmtReset;
      tgt_fmt_q <= pfc_pkg::FmtReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        pfc_pkg::CfgSrcFmt: src_fmt_q <= cfg_i.data.data;
        pfc_pkg::CfgTgtFmt: tgt_fmt_q <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  // the user must change formats only while idle (the block does not enforce it); both stages read them directly
  assign src_ok = src_fmt_q < pfc_pkg::FmtCount;
  assign tgt_ok = tgt_fmt_q < pfc_pkg::FmtCount;
  assign pass   = tgt_ok && (src_fmt_q == tgt_fmt_q);
  assign skind  = pfc_pkg::kind_e'(src_fmt_q[3:2]);
  assign tkind  = pfc_pkg::kind_e'(tgt_fmt_q[3:2]);

  always_comb begin
    case (tkind)
      pfc_pkg::KindUnorm8: pass_mask = 32'h0000_00FF;
      pfc_pkg::KindHalf:   pass_mask = 32'h0000_FFFF;
      default:             pass_mask = 32'hFFFF_FFFF;
    endcase
  end

  assign raw[0] = in_i.data.in_red;
  assign raw[1] = in_i.data.in_green;
  assign raw[2] = in_i.data.in_blue;
  assign raw[3] = in_i.data.in_alpha;

  // stage 1: decode lanes
  for (genvar g = 0; g < L; g++) begin : g_lane
    pfc_decode u_dec (
      .kind_i (skind),
      .raw_i  (raw[g]),
      .flt_o  (dec[g])
    );

    always_comb begin
      if (pass) begin
        // equal, valid formats bypass the float path
        color_d[g] = raw[g] & pass_mask;
      end else if (src_ok && (2'(g) <= src_fmt_q[1:0])) begin
        color_d[g] = dec[g];
      end else if (g == L - 1) begin
        // missing alpha reads as one
        color_d[g] = pfc_pkg::BitsOne;
      end else begin
        color_d[g] = '0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (s1_en && in_i.valid) begin
        color_q[g] <= color_d[g];
      end
    end

    // stage 2: encode lanes
    pfc_encode u_enc (
      .kind_i (tkind),
      .flt_i  (color_q[g]),
      .enc_o  (enc[g])
    );

    always_comb begin
      if (!tgt_ok || (2'(g) > tgt_fmt_q[1:0])) begin
        res[g] = '0;
      end else if (pass) begin
        res[g] = color_q[g];
      end else begin
        res[g] = enc[g];
      end
    end
  end

  // merge lanes into the output word
  assign out_d.out_red   = res[0];
  assign out_d.out_green = res[1];
  assign out_d.out_blue  = res[2];
  assign out_d.out_alpha = res[3];

  // each stage moves when the one after it has room
  assign s2_en      = !s2_valid_q || out_o.ready;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_i.ready = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_i.valid;
      if (s2_en) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = s2_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

@@ sv/pfc_decode.sv @@
// ----------------------------------------------------------------------------
// pfc_decode
// one lane: expands a raw channel word to float32 bits
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_decode (
  input  pfc_pkg::kind_e           kind_i,
  input  logic [pfc_pkg::ChanW-1:0] raw_i,
  output logic [pfc_pkg::ChanW-1:0] flt_o
);

  logic [7:0]  x;
  logic [2:0]  p8;
  logic [63:0] rep;
  logic [63:0] rep_sh;
  logic [30:0] u8_mag;
  logic [31:0] u8_bits;
  logic [4:0]  e5;
  logic [9:0]  m10;
  logic [3:0]  q;
  logic [10:0] m_norm;
  logic [31:0] h_bits;

  // unorm8: x/255 in binary is the byte x repeated forever, so the tail past
  // the guard bit is never zero and a set guard bit always rounds up
  always_comb begin
    x  = raw_i[7:0];
    p8 = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) p8 = 3'(i);
    end
    rep    = {8{x}};
    rep_sh = rep << (3'd7 - p8);
    u8_mag = {8'(8'd119 + {5'd0, p8}), rep_sh[62:40]} + {30'd0, rep_sh[39]};
    if (x == 8'd0) begin
      u8_bits = '0;
    end else if (x == 8'hFF) begin
      u8_bits = pfc_pkg::BitsOne;
    end else begin
      u8_bits = {1'b0, u8_mag};
    end
  end

  // half: exact widening, subnormals normalized
  always_comb begin
    e5  = raw_i[14:10];
    m10 = raw_i[9:0];
    q   = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m10[i]) q = 4'(i);
    end
    m_norm = {1'b0, m10} << (4'd10 - q);
    if (e5 == 5'h1F) begin
      h_bits = {raw_i[15], 8'hFF, m10, 13'd0};
    end else if (e5 != 5'd0) begin
      h_bits = {raw_i[15], 8'({3'd0, e5} + 8'd112), m10, 13'd0};
    end else if (m10 == 10'd0) begin
      h_bits = {raw_i[15], 31'd0};
    end else begin
      h_bits = {raw_i[15], 8'(8'd103 + {4'd0, q}), m_norm[9:0], 13'd0};
    end
  end

  always_comb begin
    case (kind_i)
      pfc_pkg::KindUnorm8: flt_o = u8_bits;
      pfc_pkg::KindHalf:   flt_o = h_bits;
      default:             flt_o = raw_i;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/pfc_encode.sv @@
// ----------------------------------------------------------------------------
// pfc_encode
// one lane: encodes float32 bits for the destination channel type
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_encode (
  input  pfc_pkg::kind_e           kind_i,
  input  logic [pfc_pkg::ChanW-1:0] flt_i,
  output logic [pfc_pkg::ChanW-1:0] enc_o
);

  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] man;
  logic        nan;
  // unorm8 path
  logic [31:0] prod;
  logic [23:0] r0;
  logic        g8;
  logic        st8;
  logic [24:0] r8;
  logic [4:0]  sh8;
  logic [24:0] q8;
  logic [7:0]  u8;
  // half path
  logic [31:0] cb;
  logic [7:0]  cex;
  logic [23:0] mfull;
  logic [4:0]  shh;
  logic [24:0] mask;
  logic [24:0] rem;
  logic [24:0] hw;
  logic [10:0] hsub;
  logic [14:0] hn;
  logic [12:0] remn;
  logic [15:0] hb;

  always_comb begin
    sgn  = flt_i[31];
    ex   = flt_i[30:23];
    man  = flt_i[22:0];
    nan  = (ex == 8'hFF) && (man != 23'd0);
    // x*255 rounded to single, then truncated
    prod = 32'({1'b1, man}) * 32'd255;
    if (prod[31]) begin
      r0  = prod[31:8];
      g8  = prod[7];
      st8 = |prod[6:0];
      sh8 = 5'(8'd142 - ex);
    end else begin
      r0  = prod[30:7];
      g8  = prod[6];
      st8 = |prod[5:0];
      sh8 = 5'(8'd143 - ex);
    end
    r8 = {1'b0, r0} + {24'd0, g8 && (st8 || r0[0])};
    q8 = r8 >> sh8;
    if (nan || sgn || (flt_i[30:0] == 31'd0) || (ex < 8'd119)) begin
      u8 = 8'd0;
    end else if (ex >= 8'd127) begin
      u8 = 8'hFF;
    end else begin
      u8 = q8[7:0];
    end
  end

  always_comb begin
    // clamp to the largest half magnitude; infinity is caught here too
    if (!nan && (flt_i[30:0] > pfc_pkg::HalfMaxMag)) begin
      cb = {sgn, pfc_pkg::HalfMaxMag};
    end else begin
      cb = flt_i;
    end
    cex   = cb[30:23];
    mfull = {1'b1, cb[22:0]};
    shh   = 5'(8'd126 - cex);
    mask  = (25'd1 << shh) - 25'd1;
    rem   = {1'b0, mfull} & mask;
    hw    = 25'd1 << (shh - 5'd1);
    hsub  = 11'(mfull >> shh);
    if ((rem > hw) || ((rem == hw) && hsub[0])) begin
      hsub = hsub + 11'd1;
    end
    hn   = {5'(cex - 8'd112), cb[22:13]};
    remn = cb[12:0];
    if ((remn > 13'h1000) || ((remn == 13'h1000) && hn[0])) begin
      hn = hn + 15'd1;
    end
    if (cex == 8'hFF) begin
      hb = {sgn, 15'h7E00};
    end else if (cex > 8'd112) begin
      hb = {sgn, hn};
    end else if (cex < 8'd102) begin
      hb = {sgn, 15'd0};
    end else begin
      hb = {sgn, 4'd0, hsub};
    end
  end

  always_comb begin
    case (kind_i)
      pfc_pkg::KindUnorm8: enc_o = {24'd0, u8};
      pfc_pkg::KindHalf:   enc_o = {16'd0, hb};
      default:             enc_o = flt_i;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/pfc_chk.sv @@
// ----------------------------------------------------------------------------
// pfc_chk
// port-level checks of the pixel format converter
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_format_converter_defines.svh"

module pfc_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic cfg_valid_i,
  input logic cfg_ready_i
);

  // a held output word stays valid
  `PFC_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "output word dropped")

  // with the output empty the pipeline has room
  `PFC_ASSERT(a_ready_empty, !out_valid_i |-> in_ready_i, "stalled with empty output")

  // config writes are taken at once
  `PFC_ASSERT_ALWAYS(a_cfg_ready, cfg_valid_i |-> cfg_ready_i, "config write stalled")

  // no output word without an earlier input word
  `PFC_ASSERT(a_out_src, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2),
              "output word without input")

endmodule

bind pixel_format_converter pfc_chk u_pfc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);

`default_nettype wire

@@ tb/pixel_format_converter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_format_converter_tb
// self-checking bench for the pixel format converter: a directed table of
// corner pixels, then random pixels under changing formats and handshake
// pressure, each output word checked against an integer-exact predictor
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_format_converter_tb;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned ItemsPerRun = 90;
  localparam int unsigned DrainCycles = 6;

  typedef struct {
    logic [pfc_pkg::FmtW-1:0] src;
    logic [pfc_pkg::FmtW-1:0] tgt;
    pfc_pkg::pix_in_t         pix;
    bit                       known;
    pfc_pkg::pix_out_t        want;
  } corner_row_t;

  logic clk;
  logic rst_n;

  pfc_cfg_if cfg_if ();
  pfc_in_if  in_if ();
  pfc_out_if out_if ();

  pixel_format_converter u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // bench copy of the two format registers
  logic [pfc_pkg::FmtW-1:0] src_fmt;
  logic [pfc_pkg::FmtW-1:0] tgt_fmt;

  pfc_pkg::pix_out_t pending_pixels[$];
  bit       failed;
  int       idle_pct;
  int       stall_pct;
  int       hold_left;

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // ------------------------------------------------------------ predictor

  // exact float32 of n/255, round to nearest even
  function automatic logic [31:0] unorm_expand(logic [7:0] n);
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    int k;
    if (n == 8'd0) return 32'd0;
    for (k = 23; k < 40; k++) begin
      num = {56'd0, n} << k;
      quo = num / 255;
      if (quo >= 64'h80_0000) break;
    end
    rem = num % 255;
    if (2 * rem > 255) quo++;
    if (quo == 64'h100_0000) begin
      quo = quo >> 1;
      k--;
    end
    return {1'b0, 8'(150 - k), quo[22:0]};
  endfunction

  function automatic logic [31:0] half_widen(logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  ex5;
    logic [9:0]  man;
    int          ex;
    sgn = {h[15], 31'd0};
    ex5 = h[14:10];
    man = h[9:0];
    if (ex5 == 5'h1F) return sgn | 32'h7F80_0000 | ({22'd0, man} << 13);
    if (ex5 != 5'd0) return sgn | ((ex5 + 32'd112) << 23) | ({22'd0, man} << 13);
    if (man == 10'd0) return sgn;
    ex = 113;
    // normalize the subnormal mantissa
    while (man[9] == 1'b0) begin
      man = man << 1;
      ex--;
    end
    // drop the hidden one
    man = man << 1;
    ex--;
    return sgn | (32'(ex) << 23) | ({22'd0, man} << 13);
  endfunction

  function automatic logic [15:0] single_narrow(logic [31:0] b);
    logic [15:0] sgn;
    int          ex;
    int          e;
    logic [31:0] man;
    logic [31:0] m;
    logic [31:0] h;
    logic [31:0] rem;
    logic [31:0] halfway;
    int          sh;
    sgn = {b[31], 15'd0};
    ex  = int'(b[30:23]);
    man = {9'd0, b[22:0]};
    if (ex == 255) return (man != 0) ? (sgn | 16'h7E00) : (sgn | 16'h7C00);
    e = ex - 112;
    if (e >= 31) return sgn | 16'h7C00;
    if (e <= 0) begin
      m  = man | 32'h80_0000;
      sh = 14 - e;
      if (ex == 0 || sh > 24) return sgn;
      h       = m >> sh;
      rem     = m & ((32'd1 << sh) - 1);
      halfway = 32'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && h[0])) h++;
      return sgn | h[15:0];
    end
    h   = (32'(e) << 10) | (man >> 13);
    rem = man & 32'h1FFF;
    if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h++;
    return sgn | h[15:0];
  endfunction

  // saturate, scale by 255 in float32 and truncate
  function automatic logic [7:0] unorm_pack(logic [31:0] b);
    logic [7:0]  ex;
    logic [63:0] prod;
    logic [63:0] rem;
    logic [63:0] halfway;
    int          len;
    int          s;
    ex = b[30:23];
    if (ex == 8'hFF && b[22:0] != 0) return 8'd0;
    if (b[31] || b == 32'd0) return 8'd0;
    if (b >= 32'h3F80_0000) return 8'hFF;
    if (ex == 8'd0) return 8'd0;
    prod = {40'd0, 1'b1, b[22:0]} * 64'd255;
    len  = 0;
    for (int i = 0; i < 64; i++) if (prod[i]) len = i + 1;
    if (len > 24) begin
      s       = len - 24;
      rem     = prod & ((64'd1 << s) - 1);
      halfway = 64'd1 << (s - 1);
      prod    = prod >> s;
      if (rem > halfway || (rem == halfway && prod[0])) prod++;
      prod = prod << s;
    end
    return 8'(prod >> (150 - int'(ex)));
  endfunction

  function automatic logic [31:0] channel_encode(pfc_pkg::kind_e kind, logic [31:0] b);
    logic [31:0] v;
    v = b;
    case (kind)
      pfc_pkg::KindUnorm8: return {24'd0, unorm_pack(v)};
      pfc_pkg::KindHalf: begin
        // clamp to the largest half, NaN left alone
        if (!(v[30:23] == 8'hFF && v[22:0] != 0) && v[30:0] > pfc_pkg::HalfMaxMag)
          v = {v[31], pfc_pkg::HalfMaxMag};
        return {16'd0, single_narrow(v)};
      end
      default: return v;
    endcase
  endfunction

  function automatic logic [31:0] channel_decode(pfc_pkg::kind_e kind, logic [31:0] raw);
    case (kind)
      pfc_pkg::KindUnorm8: return unorm_expand(raw[7:0]);
      pfc_pkg::KindHalf:   return half_widen(raw[15:0]);
      default:             return raw;
    endcase
  endfunction

  function automatic logic [31:0] kind_mask(pfc_pkg::kind_e kind);
    case (kind)
      pfc_pkg::KindUnorm8: return 32'h0000_00FF;
      pfc_pkg::KindHalf:   return 32'h0000_FFFF;
      default:             return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic pfc_pkg::pix_out_t convert_pixel(pfc_pkg::pix_in_t p,
                                                      logic [pfc_pkg::FmtW-1:0] src,
                                                      logic [pfc_pkg::FmtW-1:0] tgt);
    logic [31:0]    raw[4];
    logic [31:0]    color[4];
    logic [31:0]    res[4];
    pfc_pkg::kind_e tkind;
    pfc_pkg::kind_e skind;
    int             tchan;
    int             schan;
    raw   = '{p.in_red, p.in_green, p.in_blue, p.in_alpha};
    res   = '{default: 32'd0};
    color = '{32'd0, 32'd0, 32'd0, pfc_pkg::BitsOne};
    if (tgt < pfc_pkg::FmtCount) begin
      tkind = pfc_pkg::kind_e'(tgt[3:2]);
      tchan = int'(tgt[1:0]) + 1;
      if (src == tgt) begin
        for (int i = 0; i < tchan; i++) res[i] = raw[i] & kind_mask(tkind);
      end else begin
        if (src < pfc_pkg::FmtCount) begin
          skind = pfc_pkg::kind_e'(src[3:2]);
          schan = int'(src[1:0]) + 1;
          for (int i = 0; i < schan; i++) color[i] = channel_decode(skind, raw[i]);
        end
        for (int i = 0; i < tchan; i++)
          res[i] = channel_encode(tkind, color[i]) & kind_mask(tkind);
      end
    end
    return '{res[0], res[1], res[2], res[3]};
  endfunction

  // ------------------------------------------------------------- stimulus

  // mix of raw noise and float-shaped values that hit rounding and clamping
  function automatic logic [31:0] random_channel();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0, 1: ;
      2: v = {v[31], 8'($urandom_range(100, 150)), v[22:0]};
      3: v = {v[31], 8'($urandom_range(110, 127)), v[22:13], 13'h1000};
      4: v = {v[31], 8'($urandom_range(140, 145)), v[22:0]};
      5: v = {v[31], ($urandom_range(1) != 0) ? 8'hFF : 8'h00,
              ($urandom_range(1) != 0) ? v[22:0] : 23'd0};
      6: v = {v[31:16], v[15], 5'($urandom_range(0, 31)), v[9:0]};
      default: v = {v[31:8], 8'($urandom_range(255))};
    endcase
    return v;
  endfunction

  task automatic send_pixel(pfc_pkg::pix_in_t p);
    forever begin
      @(negedge clk);
      if ($urandom_range(99) < idle_pct) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid <= 1'b1;
        in_if.data  <= p;
        break;
      end
    end
    do @(posedge clk); while (!in_if.ready);
    pending_pixels.push_back(convert_pixel(p, src_fmt, tgt_fmt));
  endtask

  // wait until every output word is back and the pipeline is empty
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(pfc_pkg::cfg_idx_e idx, logic [pfc_pkg::FmtW-1:0] val);
    @(negedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == pfc_pkg::CfgSrcFmt) src_fmt = val;
    else tgt_fmt = val;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_formats(logic [pfc_pkg::FmtW-1:0] src, logic [pfc_pkg::FmtW-1:0] tgt);
    if (src != src_fmt || tgt != tgt_fmt) drain();
    if (src != src_fmt) write_reg(pfc_pkg::CfgSrcFmt, src);
    if (tgt != tgt_fmt) write_reg(pfc_pkg::CfgTgtFmt, tgt);
  endtask

  // mostly legal codes, the two ends often, invalid ones now and then
  function automatic logic [pfc_pkg::FmtW-1:0] random_format();
    case ($urandom_range(9))
      0:       return 4'd0;
      1:       return 4'd11;
      2:       return 4'($urandom_range(12, 15));
      default: return 4'($urandom_range(0, 11));
    endcase
  endfunction

  task automatic random_run(int count);
    pfc_pkg::pix_in_t p;
    for (int i = 0; i < count; i++) begin
      p = '{random_channel(), random_channel(), random_channel(), random_channel()};
      send_pixel(p);
    end
  endtask

  // corner pixels; expectations typed in where they are obvious
  corner_row_t corners[] = '{
    // after reset: rgba unorm8 passthrough, upper bits masked
    '{4'd3, 4'd3, '{32'h1FF, 32'h1234, 32'hABCDEF80, 32'hFFFFFFFF}, 1'b1,
      '{32'hFF, 32'h34, 32'h80, 32'hFF}},
    '{4'd3, 4'd11, '{32'hFF, 32'h0, 32'h0, 32'hFF}, 1'b1,
      '{32'h3F800000, 32'h0, 32'h0, 32'h3F800000}},
    // missing channels: rgb zero, alpha one
    '{4'd0, 4'd11, '{32'hFFFFFF00, 32'hFF, 32'hFF, 32'h0}, 1'b1,
      '{32'h0, 32'h0, 32'h0, 32'h3F800000}},
    '{4'd0, 4'd7, '{32'hFF, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{32'h3C00, 32'h0, 32'h0, 32'h3C00}},
    // half nan to unorm8
    '{4'd4, 4'd0, '{32'h7E01, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{32'h0, 32'h0, 32'h0, 32'h0}},
    '{4'd7, 4'd7, '{32'hFFFF7C00, 32'h12345678, 32'h0, 32'hFFFF}, 1'b1,
      '{32'h7C00, 32'h5678, 32'h0, 32'hFFFF}},
    // infinities clamp, nans keep sign
    '{4'd11, 4'd7, '{32'h7F800000, 32'hFF800000, 32'h7FC00001, 32'hFFC00000}, 1'b1,
      '{32'h7BFF, 32'hFBFF, 32'h7E00, 32'hFE00}},
    '{4'd11, 4'd7, '{32'h477FF000, 32'h00000001, 32'h80000000, 32'h3F800000}, 1'b1,
      '{32'h7BFF, 32'h0, 32'h8000, 32'h3C00}},
    // unorm8 saturation
    '{4'd11, 4'd3, '{32'h40000000, 32'hBF800000, 32'h7F800000, 32'h3F800000}, 1'b1,
      '{32'hFF, 32'h0, 32'hFF, 32'hFF}},
    '{4'd11, 4'd3, '{32'h3F000000, 32'h3B800000, 32'h3F7FFFFF, 32'h00400000}, 1'b0,
      '{default: 32'h0}},
    // invalid target codes, even when equal to source, then an invalid source code
    '{4'd11, 4'd12, '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1,
      '{32'h0, 32'h0, 32'h0, 32'h0}},
    '{4'd12, 4'd12, '{32'h1, 32'h2, 32'h3, 32'h4}, 1'b1,
      '{32'h0, 32'h0, 32'h0, 32'h0}},
    '{4'd15, 4'd11, '{32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0}, 1'b1,
      '{32'h0, 32'h0, 32'h0, 32'h3F800000}},
    // half subnormals and specials widen exactly
    '{4'd7, 4'd11, '{32'h0001, 32'h8000, 32'h7C00, 32'hFC00}, 1'b1,
      '{32'h33800000, 32'h80000000, 32'h7F800000, 32'hFF800000}},
    '{4'd7, 4'd11, '{32'h03FF, 32'h83FF, 32'h7BFF, 32'h7FFF}, 1'b0,
      '{default: 32'h0}},
    '{4'd11, 4'd11, '{32'hFFFFFFFF, 32'h0, 32'h80000000, 32'h7FFFFFFF}, 1'b1,
      '{32'hFFFFFFFF, 32'h0, 32'h80000000, 32'h7FFFFFFF}},
    '{4'd3, 4'd1, '{32'h80, 32'h7F, 32'h01, 32'hFE}, 1'b0, '{default: 32'h0}},
    '{4'd8, 4'd2, '{32'h3EAAAAAB, 32'h0, 32'h0, 32'h0}, 1'b0, '{default: 32'h0}},
    '{4'd5, 4'd10, '{32'h0200, 32'h3555, 32'h0, 32'h0}, 1'b0, '{default: 32'h0}},
    '{4'd0, 4'd0, '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 32'h1}, 1'b1,
      '{32'hFF, 32'h0, 32'h0, 32'h0}}
  };

  // ------------------------------------------------------ output receiver
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ------------------------------------------------------- output checker
  always @(posedge clk) begin
    pfc_pkg::pix_out_t want;
    logic [31:0]       w[4];
    logic [31:0]       g[4];
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_if.data);
        failed = 1'b1;
      end else begin
        want = pending_pixels.pop_front();
        w = '{want.out_red, want.out_green, want.out_blue, want.out_alpha};
        g = '{out_if.data.out_red, out_if.data.out_green,
              out_if.data.out_blue, out_if.data.out_alpha};
        for (int i = 0; i < 4; i++) begin
          if (w[i] !== g[i]) begin
            $display("%0t: channel %0d expected %h actual %h", $time, i, w[i], g[i]);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------- watchdog
  initial begin
    #(20ms);
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------- main thread
  initial begin
    // idle modes: none, sender, receiver, both
    int idle_modes[4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{18, 18}};
    pfc_pkg::pix_out_t got;

    failed       = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_left    = 0;
    src_fmt      = pfc_pkg::FmtReset;
    tgt_fmt      = pfc_pkg::FmtReset;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    rst_n        = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corner table
    foreach (corners[r]) begin
      set_formats(corners[r].src, corners[r].tgt);
      send_pixel(corners[r].pix);
      if (corners[r].known) begin
        got = pending_pixels.pop_back();
        if (got !== corners[r].want) begin
          $display("%0t: corner row %0d expected %h actual %h", $time, r,
                   corners[r].want, got);
          failed = 1'b1;
        end
        pending_pixels.push_back(corners[r].want);
      end
    end

    // random part, format extremes first
    for (int ph = 0; ph < 9; ph++) begin
      idle_pct  = idle_modes[ph % 4][0];
      stall_pct = idle_modes[ph % 4][1];
      case (ph)
        0:       set_formats(4'd0, 4'd11);
        1:       set_formats(4'd11, 4'd0);
        2:       set_formats(4'd11, 4'd7);
        3:       set_formats(4'd7, 4'd3);
        default: set_formats(random_format(), random_format());
      endcase
      if (ph == 4) begin
        // long receiver hold while pixels keep coming: the block must stall
        hold_left = 300;
        random_run(30);
        drain();
      end
      random_run(ItemsPerRun);
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (!failed && pending_pixels.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/pfc_pkg.sv
sv/pfc_if.sv
sv/pfc_decode.sv
sv/pfc_encode.sv
sv/pixel_format_converter.sv
sv/pfc_chk.sv
tb/pixel_format_converter_tb.sv
